// ===== hdl/lfu_cache_lru_tiebreak_core_assert.svh =====
// Assertion macros for the LFU cache core.
`ifndef LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH
// Implication checked every clock, off during reset.
`define LFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked every clock, off during reset.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== hdl/lfu_pkg.sv =====
// Package with shared types and constants of the LFU cache core.
package lfu_pkg;
   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CAP_BITS   = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE, ST_RESP
   } state_type;

   typedef struct packed {
      logic start;      // load request, clear scan
      logic scan;       // examine entry at scan index
      logic update;     // apply the update
      logic resp_load;  // capture result
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;
endpackage

// ===== hdl/lfu_if.sv =====
// Valid/ready channel interfaces of the LFU cache core.
interface lfu_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [lfu_pkg::KEY_BITS-1:0]   key;
   logic [lfu_pkg::VALUE_BITS-1:0] value;
   modport source (output valid, cmd, key, value, input ready);
   modport sink (input valid, cmd, key, value, output ready);
endinterface

interface lfu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lfu_pkg::VALUE_BITS-1:0] read_value;
   logic                          evicted;
   logic [lfu_pkg::KEY_BITS-1:0]   evicted_key;
   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lfu_pkg::CAP_BITS-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== hdl/lfu_ctrl.sv =====
// Controller state machine of the LFU cache core.
module lfu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lfu_pkg::status_type  status,
   output lfu_pkg::cmd_type     cmd,
   output logic                 req_ready
);
   lfu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfu_pkg::ST_IDLE:   if (req_fire) state_in = lfu_pkg::ST_SCAN;
         lfu_pkg::ST_SCAN:   if (status.scan_last) state_in = lfu_pkg::ST_DECIDE;
         lfu_pkg::ST_DECIDE: state_in = lfu_pkg::ST_UPDATE;
         lfu_pkg::ST_UPDATE: state_in = lfu_pkg::ST_RESP;
         lfu_pkg::ST_RESP:   if (!rsp_valid || rsp_ready) state_in = lfu_pkg::ST_IDLE;
         default:            state_in = lfu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_fire;
         end
         lfu_pkg::ST_SCAN:   cmd.scan = 1'b1;
         lfu_pkg::ST_DECIDE: ;
         lfu_pkg::ST_UPDATE: cmd.update = 1'b1;
         lfu_pkg::ST_RESP:   cmd.resp_load = !rsp_valid || rsp_ready;
         default: ;
      endcase
   end
endmodule

// ===== hdl/lfu_dp.sv =====
// Datapath of the LFU cache core: entry table, scan, update, result register.
`include "lfu_cache_lru_tiebreak_core_assert.svh"
module lfu_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lfu_pkg::cmd_type               cmd,
   output lfu_pkg::status_type            status,
   input  logic                           in_cmd,
   input  logic [lfu_pkg::KEY_BITS-1:0]   in_key,
   input  logic [lfu_pkg::VALUE_BITS-1:0] in_value,
   input  logic [lfu_pkg::CAP_BITS-1:0]   capacity,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [lfu_pkg::VALUE_BITS-1:0] rsp_read_value,
   output logic                           rsp_evicted,
   output logic [lfu_pkg::KEY_BITS-1:0]   rsp_evicted_key
);
   localparam int D  = lfu_pkg::DEPTH;
   localparam int IB = lfu_pkg::IDX_BITS;
   localparam int NB = lfu_pkg::CNT_BITS;
   localparam int CB = lfu_pkg::COUNT_BITS;
   localparam logic [CB-1:0] CMAX = '1;

   logic [D-1:0]                   valid_ff, valid_in;
   logic [lfu_pkg::KEY_BITS-1:0]   key_ff [D];
   logic [lfu_pkg::VALUE_BITS-1:0] val_ff [D];
   logic [CB-1:0]                  cnt_ff [D];
   logic [IB-1:0]                  age_ff [D];

   // request
   logic                           op_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   rkey_ff;
   logic [lfu_pkg::VALUE_BITS-1:0] rval_ff;
   // scan state
   logic [IB-1:0] idx_ff;
   logic [NB-1:0] n_ff;
   logic          found_ff, have_ff, free_ok_ff;
   logic [IB-1:0] slot_ff, vic_ff, free_ff;
   // computed result, held until the output register is free
   logic                           p_hit_ff, p_ev_ff;
   logic [lfu_pkg::VALUE_BITS-1:0] p_rd_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   p_evk_ff;
   // output register
   logic                           rv_ff, hit_ff, ev_ff;
   logic [lfu_pkg::VALUE_BITS-1:0] rd_ff;
   logic [lfu_pkg::KEY_BITS-1:0]   evk_ff;

   logic e_valid, e_match, e_better;
   assign e_valid = valid_ff[idx_ff];
   assign e_match = e_valid && key_ff[idx_ff] == rkey_ff;
   assign e_better = e_valid && (!have_ff || cnt_ff[idx_ff] < cnt_ff[vic_ff] ||
      (cnt_ff[idx_ff] == cnt_ff[vic_ff] && age_ff[idx_ff] > age_ff[vic_ff]));
   assign status.scan_last = idx_ff == IB'(D - 1);

   // effective capacity
   logic [NB:0] cap_eff;
   always_comb begin
      priority if (capacity == '0) cap_eff = (NB+1)'(1);
      else if (32'(capacity) > D) cap_eff = (NB+1)'(D);
      else cap_eff = (NB+1)'(capacity);
   end

   // update decisions
   logic do_evict, do_insert, do_touch;
   logic [IB-1:0] ins_idx;
   always_comb begin
      do_touch  = found_ff;
      do_evict  = !found_ff && op_ff == lfu_pkg::CMD_PUT &&
                  (NB+1)'(n_ff) >= cap_eff && have_ff;
      do_insert = !found_ff && op_ff == lfu_pkg::CMD_PUT;
      ins_idx   = (do_evict && (!free_ok_ff || vic_ff < free_ff)) ? vic_ff : free_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      if (do_evict) valid_in[vic_ff] = 1'b0;
      if (do_insert) valid_in[ins_idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rv_ff    <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (cmd.start) begin
            op_ff <= in_cmd; rkey_ff <= in_key; rval_ff <= in_value;
            idx_ff <= '0; n_ff <= '0; found_ff <= 1'b0; have_ff <= 1'b0;
            free_ok_ff <= 1'b0; slot_ff <= '0; vic_ff <= '0; free_ff <= '0;
         end
         if (cmd.scan) begin
            idx_ff <= idx_ff + IB'(1);
            if (e_valid) n_ff <= n_ff + NB'(1);
            if (e_match && !found_ff) begin
               found_ff <= 1'b1; slot_ff <= idx_ff;
            end
            if (e_better) begin
               have_ff <= 1'b1; vic_ff <= idx_ff;
            end
            if (!e_valid && !free_ok_ff) begin
               free_ok_ff <= 1'b1; free_ff <= idx_ff;
            end
         end
         if (cmd.update) begin
            valid_ff <= valid_in;
            for (int i = 0; i < D; i++) begin
               if (do_touch && valid_ff[i] && IB'(i) != slot_ff &&
                   age_ff[i] < age_ff[slot_ff])
                  age_ff[i] <= age_ff[i] + IB'(1);
               if (do_insert && valid_in[i] && IB'(i) != ins_idx) begin
                  // remove victim then age everyone: net +1 only below victim rank
                  if (!do_evict || age_ff[i] < age_ff[vic_ff])
                     age_ff[i] <= age_ff[i] + IB'(1);
               end
            end
            if (do_touch) begin
               age_ff[slot_ff] <= '0;
               if (cnt_ff[slot_ff] != CMAX) cnt_ff[slot_ff] <= cnt_ff[slot_ff] + CB'(1);
               if (op_ff == lfu_pkg::CMD_PUT) val_ff[slot_ff] <= rval_ff;
            end
            if (do_insert) begin
               key_ff[ins_idx] <= rkey_ff;
               val_ff[ins_idx] <= rval_ff;
               cnt_ff[ins_idx] <= CB'(1);
               age_ff[ins_idx] <= '0;
            end
            p_hit_ff <= found_ff;
            p_rd_ff  <= (found_ff && op_ff == lfu_pkg::CMD_GET) ? val_ff[slot_ff] : '0;
            p_ev_ff  <= do_evict;
            p_evk_ff <= do_evict ? key_ff[vic_ff] : '0;
         end
         if (cmd.resp_load) begin
            rv_ff  <= 1'b1;
            hit_ff <= p_hit_ff;
            rd_ff  <= p_rd_ff;
            ev_ff  <= p_ev_ff;
            evk_ff <= p_evk_ff;
         end else if (rv_ff && rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_evicted_key = evk_ff;

   `LFU_ASSERT_IMP(a_no_hit_evict, clock, reset, rv_ff, !(hit_ff && ev_ff), "hit and evict together")
   `LFU_ASSERT_NEXT(a_scan_wraps, clock, reset, cmd.scan && status.scan_last, idx_ff == '0, "scan index did not wrap")
   `LFU_ASSERT_IMP(a_insert_room, clock, reset, cmd.update && do_insert, free_ok_ff || do_evict, "insert without a free slot")
endmodule

// ===== hdl/lfu_cache_lru_tiebreak_core.sv =====
// Top level of the LFU cache core with LRU tie-break.
// Usage:
//   req (sink): one transfer is one get (cmd 0) or put (cmd 1) with key and value.
//   rsp (source): one transfer per request: hit, read_value, evicted, evicted_key.
//   csr (sink): one transfer writes capacity (1..16; 0 acts as 1, above 16 as 16).
//   Write csr only while idle; it is always ready.
// Timing:
//   A request is taken in the idle state, then the controller walks all 16 entries,
//   one per cycle, matching the key and tracking the LFU/LRU victim and first free
//   slot; a decide state follows, then an update state writes the table and a result
//   state loads the result; a new request can be taken the cycle after the response
//   loads, since the controller takes no request while one is in progress.
// Stall:
//   The result register holds until rsp.ready; the controller waits in its result
//   state, taking no request, until the register is free.
// Reset:
//   Synchronous, active high: table empty, capacity 16, no result pending.
module lfu_cache_lru_tiebreak_core (
   input logic clock,
   input logic reset,
   lfu_req_if.sink   req,
   lfu_rsp_if.source rsp,
   lfu_csr_if.sink   csr
);
   lfu_pkg::cmd_type    cmd;
   lfu_pkg::status_type status;
   logic [lfu_pkg::CAP_BITS-1:0] cap_ff;
   logic req_fire;

   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lfu_pkg::CAP_RESET;
      end else if (csr.valid) begin
         cap_ff <= csr.data;
      end
   end

   lfu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd), .req_ready(req.ready)
   );

   lfu_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_cmd(req.cmd), .in_key(req.key), .in_value(req.value),
      .capacity(cap_ff), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_hit(rsp.hit), .rsp_read_value(rsp.read_value),
      .rsp_evicted(rsp.evicted), .rsp_evicted_key(rsp.evicted_key)
   );
endmodule

// ===== sim/lfu_tb_if.sv =====
// Testbench package: size of the run.
package lfu_tb_pkg;
   localparam int RUN_ITEMS = 650;
endpackage

// ===== sim/testbench.sv =====
// Testbench of the LFU cache core: directed and random gets and puts checked against a local cache model.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                           cmd;
      logic [lfu_pkg::KEY_BITS-1:0]   key;
      logic [lfu_pkg::VALUE_BITS-1:0] value;
   } op_type;

   typedef struct packed {
      logic                           hit;
      logic [lfu_pkg::VALUE_BITS-1:0] read_value;
      logic                           evicted;
      logic [lfu_pkg::KEY_BITS-1:0]   evicted_key;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfu_req_if req ();
   lfu_rsp_if rsp ();
   lfu_csr_if csr ();

   lfu_cache_lru_tiebreak_core u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cache model state
   logic [lfu_pkg::CAP_BITS-1:0]   cap_reg;
   logic                           m_valid [lfu_pkg::DEPTH];
   logic [lfu_pkg::KEY_BITS-1:0]   m_key   [lfu_pkg::DEPTH];
   logic [lfu_pkg::VALUE_BITS-1:0] m_value [lfu_pkg::DEPTH];
   logic [lfu_pkg::COUNT_BITS-1:0] m_count [lfu_pkg::DEPTH];
   int unsigned                    m_age   [lfu_pkg::DEPTH];   // 0 = most recent

   op_type      pending_ops [$];
   outcome_type expected_outcomes [$];
   int          errors = 0;
   int          n_hits = 0, n_evicts = 0, n_done = 0;
   int          send_idle_pct = 0, recv_stall_pct = 0;
   logic [lfu_pkg::KEY_BITS-1:0] key_pool [8];
   bit          req_done = 1'b0;   // request transfer at the last rising edge

   function automatic void add_op(op_type op);
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   // Apply one operation to the model and return what the core should answer.
   function automatic outcome_type cache_access(op_type op);
      outcome_type res;
      int eff, occ, slot, victim, i;
      int unsigned r;
      res = '0;
      eff = (cap_reg == 0) ? 1 :
            ((cap_reg > lfu_pkg::DEPTH) ? lfu_pkg::DEPTH : int'(cap_reg));
      occ = 0;
      slot = -1;
      for (i = 0; i < lfu_pkg::DEPTH; i++) begin
         if (m_valid[i]) begin
            occ++;
            if (slot < 0 && m_key[i] == op.key) slot = i;
         end
      end
      if (slot >= 0) begin
         res.hit = 1'b1;
         if (m_count[slot] != '1) m_count[slot]++;
         r = m_age[slot];
         for (i = 0; i < lfu_pkg::DEPTH; i++)
            if (m_valid[i] && i != slot && m_age[i] < r) m_age[i]++;
         m_age[slot] = 0;
         if (op.cmd == lfu_pkg::CMD_PUT) m_value[slot] = op.value;
         else res.read_value = m_value[slot];
         return res;
      end
      if (op.cmd == lfu_pkg::CMD_GET) return res;
      if (occ >= eff) begin
         victim = -1;
         for (i = 0; i < lfu_pkg::DEPTH; i++) begin
            if (!m_valid[i]) continue;
            if (victim < 0 || m_count[i] < m_count[victim] ||
                (m_count[i] == m_count[victim] && m_age[i] > m_age[victim]))
               victim = i;
         end
         if (victim >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = m_key[victim];
            m_valid[victim] = 1'b0;
            r = m_age[victim];
            for (i = 0; i < lfu_pkg::DEPTH; i++)
               if (m_valid[i] && m_age[i] > r) m_age[i]--;
         end
      end
      for (slot = 0; slot < lfu_pkg::DEPTH; slot++)
         if (!m_valid[slot]) break;
      for (i = 0; i < lfu_pkg::DEPTH; i++)
         if (m_valid[i]) m_age[i]++;
      m_valid[slot] = 1'b1;
      m_key[slot]   = op.key;
      m_value[slot] = op.value;
      m_count[slot] = lfu_pkg::COUNT_BITS'(1);
      m_age[slot]   = 0;
      return res;
   endfunction

   // Driver: request channel fed from the pending queue, changes on falling edge.
   always @(negedge clock) begin
      op_type op;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_done) begin
         // last transfer (if any) completed at the rising edge just passed
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            op = pending_ops.pop_front();
            req.valid <= 1'b1;
            req.cmd   <= op.cmd;
            req.key   <= op.key;
            req.value <= op.value;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Response-side backpressure.
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predict on request transfer, compare on response transfer.
   always @(posedge clock) begin
      op_type op;
      outcome_type want;
      req_done = !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            op = '{cmd: req.cmd, key: req.key, value: req.value};
            expected_outcomes.insert(expected_outcomes.size(), cache_access(op));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("response transfer with nothing expected");
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               n_done++;
               if (want.hit) n_hits++;
               if (want.evicted) n_evicts++;
               if (rsp.hit !== want.hit) begin
                  $error("hit: expected %0d actual %0d", want.hit, rsp.hit);
                  errors++;
               end
               if (rsp.read_value !== want.read_value) begin
                  $error("read_value: expected %h actual %h", want.read_value, rsp.read_value);
                  errors++;
               end
               if (rsp.evicted !== want.evicted) begin
                  $error("evicted: expected %0d actual %0d", want.evicted, rsp.evicted);
                  errors++;
               end
               if (rsp.evicted_key !== want.evicted_key) begin
                  $error("evicted_key: expected %h actual %h",
                         want.evicted_key, rsp.evicted_key);
                  errors++;
               end
            end
         end
      end
   end

   // Wait until every queued op has gone and every response has come back.
   task automatic drain();
      while (pending_ops.size() > 0 || req.valid || expected_outcomes.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Capacity write, only while idle.
   task automatic write_capacity(logic [lfu_pkg::CAP_BITS-1:0] cap);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.data  <= cap;
      do @(posedge clock); while (!csr.ready);
      cap_reg = cap;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic op_type random_op();
      op_type op;
      int sel;
      sel = $urandom_range(9);
      op.cmd   = 1'($urandom_range(1));
      op.value = $urandom;
      if (sel < 8) op.key = key_pool[$urandom_range(7)];   // mostly a small key set
      else op.key = $urandom;
      return op;
   endfunction

   initial begin
      int i, ph;
      req.valid = 1'b0; req.cmd = 1'b0; req.key = '0; req.value = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.data = '0;
      cap_reg = lfu_pkg::CAP_RESET;
      for (i = 0; i < lfu_pkg::DEPTH; i++) begin
         m_valid[i] = 1'b0; m_key[i] = '0; m_value[i] = '0; m_count[i] = '0; m_age[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: misses on empty store, extremes, fill beyond reset capacity.
      add_op('{lfu_pkg::CMD_GET, '0, '0});
      add_op('{lfu_pkg::CMD_PUT, '0, '1});
      add_op('{lfu_pkg::CMD_PUT, '1, '0});
      add_op('{lfu_pkg::CMD_GET, '1, '1});
      add_op('{lfu_pkg::CMD_GET, '0, '0});
      add_op('{lfu_pkg::CMD_PUT, '0, 32'h5a5a_a5a5});   // put hit
      for (i = 0; i < 17; i++) add_op('{lfu_pkg::CMD_PUT, 32'h100 + i, i});
      drain();

      // Capacity zero acts as one; lowered below occupancy.
      write_capacity(5'd0);
      add_op('{lfu_pkg::CMD_PUT, 32'h900, 1});
      add_op('{lfu_pkg::CMD_GET, 32'h900, 0});
      drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         case (ph)
            0: write_capacity(5'd1);
            1: write_capacity(5'd31);
            2: write_capacity(5'd16);
            3: write_capacity(5'd17);
            default: write_capacity(5'($urandom_range(2, 12)));
         endcase
         for (i = 0; i < 8; i++) key_pool[i] = (ph[0]) ? $urandom : 32'($urandom_range(20));
         for (i = 0; i < lfu_tb_pkg::RUN_ITEMS / 8; i++) add_op(random_op());
         drain();
      end

      $display("covered %0d operations: %0d hits, %0d evictions, capacities 0..31",
               n_done, n_hits, n_evicts);
      if (errors == 0) $display("lfu_cache_lru_tiebreak_core test passed");
      else $display("lfu_cache_lru_tiebreak_core test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("lfu_cache_lru_tiebreak_core test failed");
      $finish;
   end
endmodule

// ===== lfu_cache_lru_tiebreak_core.f =====
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_if.sv
hdl/lfu_ctrl.sv
hdl/lfu_dp.sv
hdl/lfu_cache_lru_tiebreak_core.sv
sim/lfu_tb_if.sv
sim/testbench.sv
